### rtl/core/csd_pkg.sv
`timescale 1ns / 1ps

package csd_pkg;

   localparam int unsigned TARGET_W    = 32;
   localparam int unsigned REF_W       = 26;
   localparam int unsigned FREQ_W      = 28;
   localparam int unsigned VCO_W       = 30;
   localparam int unsigned DIVR_W      = 10;
   localparam int unsigned K_W         = 5;
   localparam int unsigned FRAC_W      = 20;
   localparam int unsigned BC_W        = 8;
   localparam int unsigned FCNT_W      = 3;
   localparam int unsigned SUM_W       = VCO_W + 8;
   localparam int unsigned P1_W        = 18;
   localparam int unsigned P2_W        = 20;
   localparam int unsigned P3_W        = 20;

   localparam int unsigned DIVIDEND_W  = VCO_W;
   localparam int unsigned DIVISOR_W   = REF_W;
   localparam int unsigned DIV_CNT_W   = 5;

   localparam logic [TARGET_W-1:0] FREQ_MIN_HZ = TARGET_W'(1000000);
   localparam logic [TARGET_W-1:0] FREQ_MAX_HZ = TARGET_W'(200000000);
   localparam logic [VCO_W-1:0]    VCO_MIN_HZ  = VCO_W'(600000000);
   localparam logic [REF_W-1:0]    REF_RESET_HZ = REF_W'(25000000);
   localparam logic [DIVR_W-1:0]   DIV_START   = DIVR_W'(4);
   localparam logic [K_W-1:0]      K_FIRST     = K_W'(2);
   localparam logic [K_W-1:0]      K_LAST      = K_W'(19);
   localparam logic [SUM_W-1:0]    P1_OFFSET   = SUM_W'(512);
   localparam logic [SUM_W-1:0]    P1_SUM_MAX  = SUM_W'(512 + 262143);

   typedef struct packed {
      logic load;
      logic search_step;
      logic start_ref;
      logic take_ref;
      logic start_red;
      logic take_red;
      logic halve;
      logic frac_init;
      logic frac_step;
      logic load_out;
   } csd_cmd_type;

   typedef struct packed {
      logic in_bad;
      logic vco_low;
      logic div_done;
      logic red_hit;
      logic k_last;
      logic c_big;
      logic frac_last;
   } csd_sts_type;

endpackage

### rtl/core/csd_div.sv
`timescale 1ns / 1ps

module csd_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [csd_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [csd_pkg::DIVISOR_W-1:0]      divisor,
   output logic                               done,
   output logic [csd_pkg::DIVIDEND_W-1:0]     quotient,
   output logic [csd_pkg::DIVISOR_W-1:0]      remainder
);
   import csd_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W-1:0]    dsr_ff, dsr_in;
   logic [DIVISOR_W:0]      trial;
   logic [DIVISOR_W:0]      diff;
   logic                    ge;
   logic                    last;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};
   assign last  = cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/core/csd_dpath.sv
`timescale 1ns / 1ps

module csd_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  csd_pkg::csd_cmd_type               cmd,
   output csd_pkg::csd_sts_type               sts,
   input  logic [csd_pkg::REF_W-1:0]          reference_hz,
   input  logic [csd_pkg::TARGET_W-1:0]       target_hz,
   output logic                               output_enabled,
   output logic [csd_pkg::P1_W-1:0]           pll_p1,
   output logic [csd_pkg::P2_W-1:0]           pll_p2,
   output logic [csd_pkg::P3_W-1:0]           pll_p3,
   output logic [csd_pkg::P1_W-1:0]           out_div_p1,
   output logic                               out_div_by_four
);
   import csd_pkg::*;

   logic                    bad_ff;
   logic [FREQ_W-1:0]       f_ff;
   logic [VCO_W-1:0]        vco_ff;
   logic [DIVR_W-1:0]       div_ff;
   logic [VCO_W-1:0]        a_ff;
   logic [REF_W-1:0]        b_ff;
   logic [REF_W-1:0]        c_ff;
   logic [K_W-1:0]          k_ff;
   logic [FRAC_W:0]         r_ff;
   logic [BC_W-1:0]         bc_ff;
   logic [FCNT_W-1:0]       fcnt_ff;

   logic                    en_ff;
   logic [P1_W-1:0]         p1_ff;
   logic [P2_W-1:0]         p2_ff;
   logic [P3_W-1:0]         p3_ff;
   logic [P1_W-1:0]         odp1_ff;
   logic                    by4_ff;

   logic [DIVIDEND_W-1:0]   l0_dividend, l1_dividend;
   logic [DIVISOR_W-1:0]    l0_divisor, k_divisor;
   logic                    l0_done, l1_done;
   logic [DIVIDEND_W-1:0]   l0_quo, l1_quo;
   logic [DIVISOR_W-1:0]    l0_rem, l1_rem;

   logic [FRAC_W:0]         f_trial;
   logic [FRAC_W:0]         f_diff;
   logic                    f_ge;
   logic [SUM_W-1:0]        p1_sum;
   logic [SUM_W-1:0]        p1_off;
   logic                    ok;
   logic [DIVR_W:0]         div_less4;

   assign k_divisor   = {{(DIVISOR_W-K_W){1'b0}}, k_ff};
   assign l0_dividend = cmd.start_red ? {{(DIVIDEND_W-REF_W){1'b0}}, b_ff} : vco_ff;
   assign l0_divisor  = cmd.start_red ? k_divisor : reference_hz;
   assign l1_dividend = {{(DIVIDEND_W-REF_W){1'b0}}, c_ff};

   // lane 0 handles vco/ref and b/k, lane 1 runs c/k alongside
   // both lanes always start together so they finish on the same cycle
   csd_div u_div0 (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_ref | cmd.start_red),
      .dividend  (l0_dividend),
      .divisor   (l0_divisor),
      .done      (l0_done),
      .quotient  (l0_quo),
      .remainder (l0_rem)
   );

   csd_div u_div1 (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_ref | cmd.start_red),
      .dividend  (l1_dividend),
      .divisor   (k_divisor),
      .done      (l1_done),
      .quotient  (l1_quo),
      .remainder (l1_rem)
   );

   // first fraction step compares without doubling so that b == c gives 128
   assign f_trial = (fcnt_ff == '0) ? r_ff : {r_ff[FRAC_W-1:0], 1'b0};
   assign f_ge    = f_trial >= {1'b0, c_ff[FRAC_W-1:0]};
   assign f_diff  = f_trial - {1'b0, c_ff[FRAC_W-1:0]};

   assign p1_sum    = {1'b0, a_ff, 7'b0} + {{(SUM_W-BC_W){1'b0}}, bc_ff};
   assign p1_off    = p1_sum - P1_OFFSET;
   assign ok        = !bad_ff && (p1_sum >= P1_OFFSET) && (p1_sum <= P1_SUM_MAX);
   assign div_less4 = {1'b0, div_ff} - {1'b0, DIV_START};

   always_comb begin
      sts.in_bad    = (target_hz < FREQ_MIN_HZ) || (target_hz > FREQ_MAX_HZ)
                      || (reference_hz == '0);
      sts.vco_low   = vco_ff < VCO_MIN_HZ;
      sts.div_done  = l0_done & l1_done;
      sts.red_hit   = (l0_rem == '0) && (l1_rem == '0);
      sts.k_last    = k_ff == K_LAST;
      sts.c_big     = |c_ff[REF_W-1:FRAC_W];
      sts.frac_last = fcnt_ff == FCNT_W'(BC_W - 1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bad_ff <= sts.in_bad;
         f_ff   <= target_hz[FREQ_W-1:0];
         vco_ff <= {target_hz[FREQ_W-1:0], 2'b00};
         div_ff <= DIV_START;
      end
      if (cmd.search_step) begin
         vco_ff <= vco_ff + {1'b0, f_ff, 1'b0};
         div_ff <= div_ff + DIVR_W'(2);
      end
      if (cmd.take_ref) begin
         a_ff <= l0_quo;
         b_ff <= l0_rem;
         c_ff <= reference_hz;
         k_ff <= K_FIRST;
      end
      if (cmd.take_red) begin
         if (sts.red_hit) begin
            b_ff <= l0_quo[REF_W-1:0];
            c_ff <= l1_quo[REF_W-1:0];
         end else begin
            k_ff <= k_ff + K_W'(1);
         end
      end
      if (cmd.halve) begin
         b_ff <= {1'b0, b_ff[REF_W-1:1]};
         c_ff <= {1'b0, c_ff[REF_W-1:1]};
      end
      if (cmd.frac_init) begin
         r_ff    <= {1'b0, b_ff[FRAC_W-1:0]};
         bc_ff   <= '0;
         fcnt_ff <= '0;
      end
      if (cmd.frac_step) begin
         r_ff    <= f_ge ? f_diff : f_trial;
         bc_ff   <= {bc_ff[BC_W-2:0], f_ge};
         fcnt_ff <= fcnt_ff + FCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         en_ff   <= ok;
         p1_ff   <= ok ? p1_off[P1_W-1:0] : '0;
         p2_ff   <= ok ? r_ff[P2_W-1:0] : '0;
         p3_ff   <= ok ? c_ff[P3_W-1:0] : '0;
         odp1_ff <= ok ? P1_W'({div_less4, 7'b0}) : '0;
         by4_ff  <= ok && (div_ff == DIV_START);
      end
   end

   assign output_enabled  = en_ff;
   assign pll_p1          = p1_ff;
   assign pll_p2          = p2_ff;
   assign pll_p3          = p3_ff;
   assign out_div_p1      = odp1_ff;
   assign out_div_by_four = by4_ff;

endmodule

### rtl/core/csd_ctrl.sv
`timescale 1ns / 1ps

module csd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output csd_pkg::csd_cmd_type   cmd,
   input  csd_pkg::csd_sts_type   sts
);
   import csd_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SEARCH  = 4'd1;
   localparam logic [3:0] ST_WAITREF = 4'd2;
   localparam logic [3:0] ST_REDUCE  = 4'd3;
   localparam logic [3:0] ST_WAITRED = 4'd4;
   localparam logic [3:0] ST_HALVE   = 4'd5;
   localparam logic [3:0] ST_FRAC    = 4'd6;
   localparam logic [3:0] ST_OUT     = 4'd7;

   logic [3:0] state_ff, state_in;
   logic       rvalid_ff, rvalid_in;
   logic       slot_free;

   assign slot_free = !rvalid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.in_bad ? ST_OUT : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (sts.vco_low) begin
               cmd.search_step = 1'b1;
            end else begin
               cmd.start_ref = 1'b1;
               state_in      = ST_WAITREF;
            end
         end
         ST_WAITREF: begin
            if (sts.div_done) begin
               cmd.take_ref = 1'b1;
               state_in     = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.start_red = 1'b1;
            state_in      = ST_WAITRED;
         end
         ST_WAITRED: begin
            if (sts.div_done) begin
               cmd.take_red = 1'b1;
               state_in     = (!sts.red_hit && sts.k_last) ? ST_HALVE : ST_REDUCE;
            end
         end
         ST_HALVE: begin
            if (sts.c_big) begin
               cmd.halve = 1'b1;
            end else begin
               cmd.frac_init = 1'b1;
               state_in      = ST_FRAC;
            end
         end
         ST_FRAC: begin
            cmd.frac_step = 1'b1;
            if (sts.frac_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (cmd.load_out) begin
         rvalid_in = 1'b1;
      end else if (!rsp_stall) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rvalid_ff;

endmodule

### rtl/core/clock_synth_divider_calc.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_target_hz
// rsp       out        rsp_valid / rsp_stall  rsp_output_enabled .. rsp_out_div_by_four
// csr       in/out     psel penable pwrite    paddr pwdata prdata pready (reference_hz at 0)
//
// one item at a time; an out-of-range target goes from its beat straight to the output state.
// in-range items: up to 298 search steps, a serial division of vco by reference,
// then a serial division per trial of a factor (at most 43 trials), up to 6
// halvings and 8 fraction steps.
// reset is synchronous and loads reference_hz with 25 MHz.
// a stalled result holds in the output register; the next req beat is taken meanwhile.

module clock_synth_divider_calc (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [csd_pkg::TARGET_W-1:0]       req_target_hz,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_output_enabled,
   output logic [csd_pkg::P1_W-1:0]           rsp_pll_p1,
   output logic [csd_pkg::P2_W-1:0]           rsp_pll_p2,
   output logic [csd_pkg::P3_W-1:0]           rsp_pll_p3,
   output logic [csd_pkg::P1_W-1:0]           rsp_out_div_p1,
   output logic                               rsp_out_div_by_four,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import csd_pkg::*;

   logic [REF_W-1:0] ref_ff, ref_in;
   csd_cmd_type      cmd;
   csd_sts_type      sts;

   // word decode, byte offset bits are ignored
   always_comb begin
      ref_in = ref_ff;
      if (psel && penable && pwrite && !paddr[2]) begin
         ref_in = pwdata[REF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_RESET_HZ;
      end else begin
         ref_ff <= ref_in;
      end
   end

   assign prdata = paddr[2] ? 32'd0 : {{(32-REF_W){1'b0}}, ref_ff};
   assign pready = 1'b1;

   csd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   csd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .reference_hz    (ref_ff),
      .target_hz       (req_target_hz),
      .output_enabled  (rsp_output_enabled),
      .pll_p1          (rsp_pll_p1),
      .pll_p2          (rsp_pll_p2),
      .pll_p3          (rsp_pll_p3),
      .out_div_p1      (rsp_out_div_p1),
      .out_div_by_four (rsp_out_div_by_four)
   );

endmodule
